@@ rtl/sfr_pkg.sv @@
// Shared types and constants of the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  // Result event codes
  typedef logic [3:0] evt_t;
  localparam evt_t EV_CHAR       = 4'd0;
  localparam evt_t EV_PAYLOAD    = 4'd1;
  localparam evt_t EV_GOOD       = 4'd2;
  localparam evt_t EV_BAD_SUM    = 4'd3;
  localparam evt_t EV_EOT        = 4'd4;
  localparam evt_t EV_ENQ        = 4'd5;
  localparam evt_t EV_ACK        = 4'd6;
  localparam evt_t EV_NACK       = 4'd7;
  localparam evt_t EV_BAD_TYPE   = 4'd8;
  localparam evt_t EV_FILE_START = 4'd9;
  localparam evt_t EV_FILE_END   = 4'd10;
  localparam evt_t EV_ROLE_SET   = 4'd11;

  // Station role
  typedef logic [1:0] role_t;
  localparam role_t ROLE_NONE   = 2'd0;
  localparam role_t ROLE_MASTER = 2'd1;
  localparam role_t ROLE_SLAVE  = 2'd2;

  // Line bytes
  typedef logic [7:0] byte_t;
  localparam byte_t BYTE_SYNC       = 8'd22;
  localparam byte_t BYTE_FILE_START = 8'd127;
  localparam byte_t BYTE_FILE_END   = 8'd8;
  localparam byte_t BYTE_MASTER     = 8'd36;
  localparam byte_t BYTE_SLAVE      = 8'd96;

  // Frame types
  localparam byte_t TYPE_DATA = 8'd2;
  localparam byte_t TYPE_EOT  = 8'd4;
  localparam byte_t TYPE_ENQ  = 8'd5;
  localparam byte_t TYPE_ACK  = 8'd6;
  localparam byte_t TYPE_NACK = 8'd21;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_EXP_ADDR = 1'b0;
  localparam cfg_idx_t CFG_EXP_NUM  = 1'b1;
  localparam byte_t EXP_ADDR_RST = 8'd84;  // 'T'
  localparam byte_t EXP_NUM_RST  = 8'd48;  // '0'

  // Parser phase
  typedef logic [2:0] phase_t;
  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_ADDR  = 3'd1;
  localparam phase_t PH_TYPE  = 3'd2;
  localparam phase_t PH_NUM   = 3'd3;
  localparam phase_t PH_CHECK = 3'd4;
  localparam phase_t PH_LEN   = 3'd5;
  localparam phase_t PH_DATA  = 3'd6;

endpackage
`default_nettype wire

@@ rtl/sfr_in_if.sv @@
// Input channel: one received serial byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface sfr_in_if;
  import sfr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/sfr_out_if.sv @@
// Result channel: one classified event per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface sfr_out_if;
  import sfr_pkg::*;
  logic  valid;
  logic  ready;
  evt_t  event_res;
  byte_t out_byte;
  logic  to_file;
  logic  address_error;
  logic  number_error;
  role_t station_role;
  modport source (output valid, output event_res, output out_byte, output to_file,
                  output address_error, output number_error, output station_role,
                  input ready);
  modport sink   (input valid, input event_res, input out_byte, input to_file,
                  input address_error, input number_error, input station_role,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/sfr_cfg_if.sv @@
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface sfr_cfg_if;
  import sfr_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/serial_frame_receiver.sv @@
// Top level of the serial frame receiver: byte classifier and frame parser.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage
//   in_ch  : one byte from the serial line per transaction (valid/ready).
//   out_ch : zero or one event per input byte: plain characters, payload
//            bytes, frame verdicts (good / bad XOR sum), control frames, file
//            start/end and role set, with address/number error flags.
//   cfg_ch : writes expected_address (index 0) or expected_number (index 1);
//            always ready, write only while no transaction is in flight.
// Latency and throughput
//   The classification and state update sit between the input handshake and
//   one result register, so an event appears on out_ch in the cycle after its
//   byte is taken. One byte is accepted every cycle; in_ch stays ready while
//   the result register is empty or being drained in the same cycle.
// Stall
//   When out_ch holds a result that is not taken, in_ch drops ready and the
//   parser state holds; nothing is lost or repeated.
// Reset
//   rst_n (synchronous, active low) empties the result register, returns the
//   parser to idle, clears flags, file mode and role, and loads the expected
//   address 'T' and expected number '0'.
//
module serial_frame_receiver (
  input  wire         clk,
  input  wire         rst_n,
  sfr_in_if.sink      in_ch,
  sfr_out_if.source   out_ch,
  sfr_cfg_if.sink     cfg_ch
);
  import sfr_pkg::*;

  // configuration
  byte_t  exp_addr_r, exp_num_r;

  // parser state
  phase_t phase_r, phase_nxt;
  byte_t  frame_type_r, frame_type_nxt;
  byte_t  check_byte_r, check_byte_nxt;
  byte_t  running_xor_r, running_xor_nxt;
  byte_t  bytes_left_r, bytes_left_nxt;
  logic   addr_flag_r, addr_flag_nxt;
  logic   num_flag_r, num_flag_nxt;
  logic   file_mode_r, file_mode_nxt;
  role_t  role_r, role_nxt;

  // result register
  logic   out_valid_r;
  evt_t   event_r;
  byte_t  out_byte_r;
  logic   to_file_r, addr_err_r, num_err_r;
  role_t  station_role_r;

  // per-byte decode
  logic   in_acc;
  logic   emit;
  evt_t   ev;
  byte_t  ob;
  logic   in_frame;   // event belongs to a frame: carry error flags
  logic   in_file;    // payload or verdict: carry file mode
  logic   skip_zero;
  byte_t  b;

  assign b      = in_ch.rx_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Zero bytes in any header position are dropped.
  assign skip_zero = (b == 8'd0) && (phase_r >= PH_ADDR) && (phase_r <= PH_LEN);

  always_comb begin
    phase_nxt       = phase_r;
    frame_type_nxt  = frame_type_r;
    check_byte_nxt  = check_byte_r;
    running_xor_nxt = running_xor_r;
    bytes_left_nxt  = bytes_left_r;
    addr_flag_nxt   = addr_flag_r;
    num_flag_nxt    = num_flag_r;
    file_mode_nxt   = file_mode_r;
    role_nxt        = role_r;
    emit     = 1'b0;
    ev       = EV_CHAR;
    ob       = 8'd0;
    in_frame = 1'b0;
    in_file  = 1'b0;
    if (in_acc && !skip_zero) begin
      case (phase_r)
        PH_ADDR: begin
          addr_flag_nxt = (b != exp_addr_r);
          phase_nxt     = PH_TYPE;
        end
        PH_TYPE: begin
          frame_type_nxt = b;
          phase_nxt      = PH_NUM;
        end
        PH_NUM: begin
          num_flag_nxt = (b != exp_num_r);
          if (frame_type_r == TYPE_DATA) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            in_frame  = 1'b1;
            case (frame_type_r)
              TYPE_EOT:  ev = EV_EOT;
              TYPE_ENQ:  ev = EV_ENQ;
              TYPE_ACK:  ev = EV_ACK;
              TYPE_NACK: ev = EV_NACK;
              default:   ev = EV_BAD_TYPE;
            endcase
          end
        end
        PH_CHECK: begin
          check_byte_nxt = b;
          phase_nxt      = PH_LEN;
        end
        PH_LEN: begin
          bytes_left_nxt  = b;
          running_xor_nxt = 8'd0;
          phase_nxt       = PH_DATA;
        end
        PH_DATA: begin
          running_xor_nxt = running_xor_r ^ b;
          if (bytes_left_r != 8'd0) begin
            bytes_left_nxt = bytes_left_r - 8'd1;
          end
          emit     = 1'b1;
          in_frame = 1'b1;
          in_file  = 1'b1;
          ob       = b;
          if (bytes_left_nxt == 8'd0) begin
            phase_nxt = PH_IDLE;
            ev = (running_xor_nxt == check_byte_r) ? EV_GOOD : EV_BAD_SUM;
          end else begin
            ev = EV_PAYLOAD;
          end
        end
        default: begin
          // idle, and any unused phase code
          phase_nxt = PH_IDLE;
          if (b == BYTE_SYNC) begin
            phase_nxt     = PH_ADDR;
            addr_flag_nxt = 1'b0;
            num_flag_nxt  = 1'b0;
          end else if (b == BYTE_FILE_END) begin
            file_mode_nxt = 1'b0;
            emit          = 1'b1;
            ev            = EV_FILE_END;
          end else if (b == BYTE_FILE_START) begin
            file_mode_nxt = 1'b1;
            emit          = 1'b1;
            ev            = EV_FILE_START;
          end else if (b == BYTE_MASTER && role_r == ROLE_NONE) begin
            role_nxt = ROLE_MASTER;
            emit     = 1'b1;
            ev       = EV_ROLE_SET;
          end else if (b == BYTE_SLAVE && role_r == ROLE_NONE) begin
            role_nxt = ROLE_SLAVE;
            emit     = 1'b1;
            ev       = EV_ROLE_SET;
          end else begin
            emit = 1'b1;
            ev   = EV_CHAR;
            ob   = b;
          end
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= EXP_ADDR_RST;
      exp_num_r  <= EXP_NUM_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_EXP_ADDR: exp_addr_r <= cfg_ch.data;
        CFG_EXP_NUM:  exp_num_r  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Parser state: advance only on an accepted byte (next values hold otherwise)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      frame_type_r  <= 8'd0;
      check_byte_r  <= 8'd0;
      running_xor_r <= 8'd0;
      bytes_left_r  <= 8'd0;
      addr_flag_r   <= 1'b0;
      num_flag_r    <= 1'b0;
      file_mode_r   <= 1'b0;
      role_r        <= ROLE_NONE;
    end else begin
      phase_r       <= phase_nxt;
      frame_type_r  <= frame_type_nxt;
      check_byte_r  <= check_byte_nxt;
      running_xor_r <= running_xor_nxt;
      bytes_left_r  <= bytes_left_nxt;
      addr_flag_r   <= addr_flag_nxt;
      num_flag_r    <= num_flag_nxt;
      file_mode_r   <= file_mode_nxt;
      role_r        <= role_nxt;
    end
  end

  // Result register: load on an accepted byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      event_r        <= ev;
      out_byte_r     <= ob;
      to_file_r      <= in_file && file_mode_r;
      addr_err_r     <= in_frame && addr_flag_nxt;
      num_err_r      <= in_frame && num_flag_nxt;
      station_role_r <= role_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = event_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.to_file       = to_file_r;
  assign out_ch.address_error = addr_err_r;
  assign out_ch.number_error  = num_err_r;
  assign out_ch.station_role  = station_role_r;

  // Events outside a frame never carry error flags.
  a_no_err_outside_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (event_r == EV_CHAR || event_r == EV_FILE_START ||
      event_r == EV_FILE_END || event_r == EV_ROLE_SET))
      |-> (!addr_err_r && !num_err_r))
    else $error("error flag set on a non-frame event");

  // A sync byte taken in idle opens a frame header.
  a_sync_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_IDLE && b == BYTE_SYNC) |=> (phase_r == PH_ADDR))
    else $error("sync byte did not start a frame");

  // Once a role is set it never changes.
  a_role_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (role_r != ROLE_NONE) |=> (role_r == $past(role_r)))
    else $error("station role changed after being set");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // Parser state holds while no byte is taken.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(phase_r) && $stable(bytes_left_r) && $stable(role_r)))
    else $error("parser state moved without an accepted byte");

endmodule
`default_nettype wire

@@ tb/sfr_checker.sv @@
// Checker for the serial frame receiver: predicts events from accepted bytes and compares.
`timescale 1ns / 1ps
module sfr_checker
  import sfr_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  input  wire      in_ready,
  input  byte_t    in_rx_byte,
  input  wire      out_valid,
  input  wire      out_ready,
  input  evt_t     out_event_res,
  input  byte_t    out_byte,
  input  wire      out_to_file,
  input  wire      out_address_error,
  input  wire      out_number_error,
  input  role_t    out_station_role,
  input  wire      cfg_valid,
  input  wire      cfg_ready,
  input  cfg_idx_t cfg_index,
  input  byte_t    cfg_data,
  output int       mismatch_count,
  output int       events_due
);

  typedef struct packed {
    evt_t  ev;
    byte_t data;
    logic  to_file;
    logic  addr_err;
    logic  num_err;
    role_t role;
  } rx_event_t;

  rx_event_t event_queue[$];
  int        fail_total = 0;
  int        due_total  = 0;

  // Receiver state as the parser sees it
  byte_t  exp_addr, exp_num;
  phase_t ph;
  byte_t  frm_type, chk, xsum, remaining;
  logic   aflag, nflag, fmode;
  role_t  st_role;

  assign mismatch_count = fail_total;
  assign events_due     = due_total;

  function automatic string event_text(input rx_event_t e);
    return $sformatf("ev=%0d byte=%h file=%b aerr=%b nerr=%b role=%0d",
                     e.ev, e.data, e.to_file, e.addr_err, e.num_err, e.role);
  endfunction

  // Advance the parser by one line byte; return 1 when it yields an event.
  function automatic bit decode_byte(input byte_t b, output rx_event_t e);
    bit    hit;
    bit    frm;
    bit    fil;
    evt_t  ev;
    byte_t d;
    hit = 1'b1;
    frm = 1'b0;
    fil = 1'b0;
    ev  = EV_CHAR;
    d   = '0;
    if (b == 8'd0 && ph inside {PH_ADDR, PH_TYPE, PH_NUM, PH_CHECK, PH_LEN}) begin
      hit = 1'b0;
    end else begin
      case (ph)
        PH_ADDR: begin
          aflag = (b != exp_addr);
          ph    = PH_TYPE;
          hit   = 1'b0;
        end
        PH_TYPE: begin
          frm_type = b;
          ph       = PH_NUM;
          hit      = 1'b0;
        end
        PH_NUM: begin
          nflag = (b != exp_num);
          if (frm_type == TYPE_DATA) begin
            ph  = PH_CHECK;
            hit = 1'b0;
          end else begin
            ph  = PH_IDLE;
            frm = 1'b1;
            case (frm_type)
              TYPE_EOT:  ev = EV_EOT;
              TYPE_ENQ:  ev = EV_ENQ;
              TYPE_ACK:  ev = EV_ACK;
              TYPE_NACK: ev = EV_NACK;
              default:   ev = EV_BAD_TYPE;
            endcase
          end
        end
        PH_CHECK: begin
          chk = b;
          ph  = PH_LEN;
          hit = 1'b0;
        end
        PH_LEN: begin
          remaining = b;
          xsum      = '0;
          ph        = PH_DATA;
          hit       = 1'b0;
        end
        PH_DATA: begin
          xsum = xsum ^ b;
          if (remaining != 0) remaining = remaining - 1'b1;
          frm = 1'b1;
          fil = 1'b1;
          d   = b;
          if (remaining == 0) begin
            ph = PH_IDLE;
            ev = (xsum == chk) ? EV_GOOD : EV_BAD_SUM;
          end else begin
            ev = EV_PAYLOAD;
          end
        end
        default: begin
          ph = PH_IDLE;
          if (b == BYTE_SYNC) begin
            ph    = PH_ADDR;
            aflag = 1'b0;
            nflag = 1'b0;
            hit   = 1'b0;
          end else if (b == BYTE_FILE_END) begin
            fmode = 1'b0;
            ev    = EV_FILE_END;
          end else if (b == BYTE_FILE_START) begin
            fmode = 1'b1;
            ev    = EV_FILE_START;
          end else if (b == BYTE_MASTER && st_role == ROLE_NONE) begin
            st_role = ROLE_MASTER;
            ev      = EV_ROLE_SET;
          end else if (b == BYTE_SLAVE && st_role == ROLE_NONE) begin
            st_role = ROLE_SLAVE;
            ev      = EV_ROLE_SET;
          end else begin
            d = b;
          end
        end
      endcase
    end
    e.ev       = ev;
    e.data     = d;
    e.to_file  = fil & fmode;
    e.addr_err = frm & aflag;
    e.num_err  = frm & nflag;
    e.role     = st_role;
    return hit;
  endfunction

  always @(posedge clk) begin
    rx_event_t predicted;
    rx_event_t wanted;
    rx_event_t seen;
    if (!rst_n) begin
      exp_addr  = EXP_ADDR_RST;
      exp_num   = EXP_NUM_RST;
      ph        = PH_IDLE;
      frm_type  = '0;
      chk       = '0;
      xsum      = '0;
      remaining = '0;
      aflag     = 1'b0;
      nflag     = 1'b0;
      fmode     = 1'b0;
      st_role   = ROLE_NONE;
      event_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_EXP_ADDR) exp_addr = cfg_data;
        else exp_num = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_rx_byte, predicted)) event_queue.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        seen = {out_event_res, out_byte, out_to_file, out_address_error,
                out_number_error, out_station_role};
        if (event_queue.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %s", $time, event_text(seen));
          fail_total++;
        end else begin
          wanted = event_queue.pop_front();
          if (seen !== wanted) begin
            $display("%0t: event mismatch, expected %s, actual %s",
                     $time, event_text(wanted), event_text(seen));
            fail_total++;
          end
        end
      end
    end
    due_total = event_queue.size();
  end

endmodule

@@ tb/tb_serial_frame_receiver.sv @@
// Testbench top for the serial frame receiver: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_serial_frame_receiver;
  import sfr_pkg::*;

  localparam int HOLD_CYCLES   = 300;        // long receiver hold-off to back up the input
  localparam int RANDOM_ITEMS  = 1700;
  localparam int IDLE_PHASES   = 4;
  localparam int DRAIN_CYCLES  = 8;          // result register is one deep
  localparam int RUN_LIMIT_NS  = 2_000_000;

  // Opening bytes after the role pair: file start, a data frame with a skipped
  // zero header byte and a zero payload byte, file end, a control frame with both
  // header errors, and a one-byte data frame with a bad sum.
  localparam byte_t OPENING_BYTES [22] = '{
    BYTE_FILE_START,
    BYTE_SYNC, EXP_ADDR_RST, 8'h00, TYPE_DATA, EXP_NUM_RST, 8'h5A, 8'd2, 8'h00, 8'h5A,
    BYTE_FILE_END,
    BYTE_SYNC, 8'hFF, TYPE_EOT, 8'h01,
    BYTE_SYNC, EXP_ADDR_RST, TYPE_DATA, EXP_NUM_RST, 8'h01, 8'h01, 8'h02
  };

  logic  clk;
  logic  rst_n;
  int    idle_pct;
  int    stall_pct;
  bit    hold_go;
  bit    hold_done;
  byte_t cur_addr;
  byte_t cur_num;
  int    sent_count;
  int    mismatches;
  int    due;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();
  sfr_cfg_if cfg_ch ();

  serial_frame_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sfr_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_rx_byte        (in_ch.rx_byte),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_event_res     (out_ch.event_res),
    .out_byte          (out_ch.out_byte),
    .out_to_file       (out_ch.to_file),
    .out_address_error (out_ch.address_error),
    .out_number_error  (out_ch.number_error),
    .out_station_role  (out_ch.station_role),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .mismatch_count    (mismatches),
    .events_due        (due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // Result side: stall at random per cycle, and once hold off for a long stretch
  // while the sender keeps offering bytes.
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one byte and hold it until the block takes it. Leave valid high on
  // return so back-to-back transactions need no gap; callers drop it when done.
  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_count++;
  endtask

  // Header position: now and then slip in a zero byte, which the parser skips.
  task automatic send_header_byte(input byte_t b);
    if ($urandom_range(9) == 0) send_byte(8'h00);
    send_byte(b);
  endtask

  function automatic byte_t nonzero_byte();
    return byte_t'($urandom_range(255, 1));
  endfunction

  // Bias noise towards the bytes that the idle classifier treats specially.
  function automatic byte_t noise_byte();
    case ($urandom_range(7))
      0:       return BYTE_SYNC;
      1:       return BYTE_FILE_START;
      2:       return BYTE_FILE_END;
      3:       return BYTE_MASTER;
      4:       return BYTE_SLAVE;
      5:       return 8'h00;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // Well-formed frame with random content: mostly matching header fields,
  // about half data frames, and checksums mostly right.
  task automatic send_random_frame();
    byte_t ftype;
    byte_t addr;
    byte_t num;
    byte_t len;
    byte_t sum;
    byte_t chk;
    byte_t body[$];
    case ($urandom_range(9))
      5:       ftype = TYPE_EOT;
      6:       ftype = TYPE_ENQ;
      7:       ftype = TYPE_ACK;
      8:       ftype = TYPE_NACK;
      9:       ftype = nonzero_byte();
      default: ftype = TYPE_DATA;
    endcase
    addr = ($urandom_range(3) == 0 || cur_addr == 0) ? nonzero_byte() : cur_addr;
    num  = ($urandom_range(3) == 0 || cur_num == 0) ? nonzero_byte() : cur_num;
    send_byte(BYTE_SYNC);
    send_header_byte(addr);
    send_header_byte(ftype);
    send_header_byte(num);
    if (ftype == TYPE_DATA) begin
      // Keep most payloads short; a rare long one exercises the upper length bits.
      len = ($urandom_range(39) == 0) ? byte_t'($urandom_range(255, 9))
                                      : byte_t'($urandom_range(6, 1));
      sum = '0;
      repeat (len) begin
        body.push_back(byte_t'($urandom_range(255)));
        sum = sum ^ body[$];
      end
      // A zero check byte would be skipped, so a zero sum always goes out as a bad one.
      chk = ($urandom_range(3) == 0 || sum == 0) ? nonzero_byte() : sum;
      send_header_byte(chk);
      send_header_byte(len);
      foreach (body[k]) send_byte(body[k]);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input byte_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Program both expected values and drop the write strobe afterwards.
  task automatic apply_config(input byte_t addr, input byte_t num);
    write_reg(CFG_EXP_ADDR, addr);
    write_reg(CFG_EXP_NUM, num);
    cfg_ch.valid <= 1'b0;
    cur_addr = addr;
    cur_num  = num;
  endtask

  // Drop valid, wait for every predicted event to drain, then let the result
  // register settle before anything touches the configuration.
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    while (due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    byte_t first_role;
    byte_t second_role;
    int    target;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_EXP_ADDR;
    cfg_ch.data   = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_go       = 1'b0;
    cur_addr      = EXP_ADDR_RST;
    cur_num       = EXP_NUM_RST;
    sent_count    = 0;
    rst_n         = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: plain characters at both extremes, then the role pair.
    // Only the first role byte is taken; the seed picks which role wins.
    send_byte(8'h00);
    send_byte(8'hFF);
    first_role  = $urandom_range(1) ? BYTE_MASTER : BYTE_SLAVE;
    second_role = (first_role == BYTE_MASTER) ? BYTE_SLAVE : BYTE_MASTER;
    send_byte(first_role);
    send_byte(second_role);
    foreach (OPENING_BYTES[k]) send_byte(OPENING_BYTES[k]);

    // Random part in idling phases: none, sender idle, receiver stalling, both.
    for (int p = 0; p < IDLE_PHASES; p++) begin
      drain_events();
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_go   = 1'b1;  // back up the block while the input keeps pushing
        end
        1: begin
          apply_config(8'h00, 8'hFF);
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          apply_config(8'hFF, 8'h00);
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          apply_config(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
          idle_pct  = 26;
          stall_pct = 26;
        end
      endcase
      target = sent_count + RANDOM_ITEMS / IDLE_PHASES;
      while (sent_count < target) begin
        if ($urandom_range(9) < 7) send_random_frame();
        else repeat ($urandom_range(4, 1)) send_byte(noise_byte());
      end
    end

    drain_events();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ serial_frame_receiver.f @@
rtl/sfr_pkg.sv
rtl/sfr_in_if.sv
rtl/sfr_out_if.sv
rtl/sfr_cfg_if.sv
rtl/serial_frame_receiver.sv
tb/sfr_checker.sv
tb/tb_serial_frame_receiver.sv
